FILE: rtl/bara_pkg.sv
// Shared types, constants and the repeat acceleration table for the button block.
package bara_pkg;

  localparam int MAX_BUTTONS   = 4;
  localparam int BTN_W         = $clog2(MAX_BUTTONS + 1);
  localparam int COORD_W       = 16;
  localparam int TIME_W        = 32;
  localparam int INTERVAL_W    = 16;
  localparam int COUNT_W       = 3;
  localparam int CD_W          = 2;
  localparam int CTR_W         = 6;
  localparam int ACCEL_LEN     = 48;
  localparam int CFG_IDX_W     = 3;
  localparam int CFG_DATA_W    = 48;
  localparam int HIT_W         = COORD_W + 2;

  localparam logic [CD_W-1:0]       PRESS_SAMPLES  = 2'd3;
  localparam logic [CTR_W-1:0]      ACCEL_TOP      = 6'd47;
  localparam logic [INTERVAL_W-1:0] INTERVAL_RESET = 16'd30;

  // Bit i is the gate entry for repeat count i.
  localparam logic [ACCEL_LEN-1:0] ACCEL_GATE = {
    16'b0111_1111_1001_0101,
    16'b0010_0100_1000_1000,
    16'b0100_0001_0000_0000
  };

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ORIGIN_X  = 3'd0,
    REG_ORIGIN_Y  = 3'd1,
    REG_BTN_COUNT = 3'd2,
    REG_INTERVAL  = 3'd3,
    REG_GEOM_0    = 3'd4,
    REG_GEOM_1    = 3'd5,
    REG_GEOM_2    = 3'd6,
    REG_GEOM_3    = 3'd7
  } cfg_reg_t;

  typedef struct packed {
    logic [COORD_W-1:0] size;
    logic [COORD_W-1:0] off_y;
    logic [COORD_W-1:0] off_x;
  } geom_t;

  typedef struct packed {
    logic [TIME_W-1:0]  now_ms;
    logic               is_down;
    logic               press_edge;
    logic [COORD_W-1:0] pointer_y;
    logic [COORD_W-1:0] pointer_x;
  } sample_t;

  typedef struct packed {
    logic [MAX_BUTTONS-1:0] pressed_mask;
    logic                   fire;
    logic [BTN_W-1:0]       active_button;
    logic [BTN_W-1:0]       focus_button;
  } result_t;

  function automatic logic accel_gate(input logic [CTR_W-1:0] idx);
    accel_gate = ACCEL_GATE[idx];
  endfunction

endpackage

FILE: rtl/button_autorepeat_accel.sv
// Top level: configuration registers, input and result registers, stream handshake.
//
// Takes one pointer sample per clock and returns one result per sample: each
// accepted sample is held in the input register, then the hit test and the
// press/repeat state update run in a single combinational pass into the
// result register. The block sustains one sample every cycle as long as out_tready
// is high; the per-button state is read and written in that one pass, so a sample
// always sees the state left by the one before it. Write the configuration port only
// while no request is in flight.
module button_autorepeat_accel (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_wr_en,
  input  logic [bara_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [bara_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // pointer_x[15:0], pointer_y[31:16], now_ms[63:32]
  input  logic [63:0]                        in_tdata,
  // press_edge[0], is_down[1]
  input  logic [1:0]                         in_tuser,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // focus_button[2:0], active_button[5:3], pressed_mask[9:6], zero fill[15:10]
  output logic [15:0]                        out_tdata,
  // fire[0]
  output logic                               out_tuser
);

  logic [bara_pkg::COORD_W-1:0]    origin_x_r, origin_y_r;
  logic [bara_pkg::COUNT_W-1:0]    btn_count_r;
  logic [bara_pkg::INTERVAL_W-1:0] interval_r;
  bara_pkg::geom_t                 geom_r [bara_pkg::MAX_BUTTONS];
  logic [bara_pkg::BTN_W-1:0]      n_used;

  bara_pkg::sample_t sample_r;
  logic              s1_vld_r;
  bara_pkg::result_t result_r, result_nxt;
  logic              out_vld_r;
  logic              advance;
  logic [bara_pkg::BTN_W-1:0] focus;

  // Counts past the number of buttons saturate.
  assign n_used = (bara_pkg::BTN_W'(btn_count_r) > bara_pkg::BTN_W'(bara_pkg::MAX_BUTTONS)) ?
                  bara_pkg::BTN_W'(bara_pkg::MAX_BUTTONS) : bara_pkg::BTN_W'(btn_count_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      origin_x_r  <= '0;
      origin_y_r  <= '0;
      btn_count_r <= '0;
      interval_r  <= bara_pkg::INTERVAL_RESET;
      for (int i = 0; i < bara_pkg::MAX_BUTTONS; i++) begin
        geom_r[i] <= '0;
      end
    end else if (cfg_wr_en) begin
      case (bara_pkg::cfg_reg_t'(cfg_index))
        bara_pkg::REG_ORIGIN_X:  origin_x_r  <= cfg_wdata[bara_pkg::COORD_W-1:0];
        bara_pkg::REG_ORIGIN_Y:  origin_y_r  <= cfg_wdata[bara_pkg::COORD_W-1:0];
        bara_pkg::REG_BTN_COUNT: btn_count_r <= cfg_wdata[bara_pkg::COUNT_W-1:0];
        bara_pkg::REG_INTERVAL:  interval_r  <= cfg_wdata[bara_pkg::INTERVAL_W-1:0];
        bara_pkg::REG_GEOM_0:    geom_r[0]   <= cfg_wdata;
        bara_pkg::REG_GEOM_1:    geom_r[1]   <= cfg_wdata;
        bara_pkg::REG_GEOM_2:    geom_r[2]   <= cfg_wdata;
        bara_pkg::REG_GEOM_3:    geom_r[3]   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Move a request into the result register whenever that slot is free or draining.
  assign advance   = s1_vld_r && (!out_vld_r || out_tready);
  assign in_tready = !s1_vld_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (in_tready) begin
        s1_vld_r <= in_tvalid;
      end
      if (advance) begin
        out_vld_r <= 1'b1;
      end else if (out_tready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      sample_r.pointer_x  <= in_tdata[15:0];
      sample_r.pointer_y  <= in_tdata[31:16];
      sample_r.now_ms     <= in_tdata[63:32];
      sample_r.press_edge <= in_tuser[0];
      sample_r.is_down    <= in_tuser[1];
    end
    if (advance) begin
      result_r <= result_nxt;
    end
  end

  bara_hit u_hit (
    .origin_x  (origin_x_r),
    .origin_y  (origin_y_r),
    .n_used    (n_used),
    .geom      (geom_r),
    .pointer_x (sample_r.pointer_x),
    .pointer_y (sample_r.pointer_y),
    .focus     (focus)
  );

  bara_state u_state (
    .clk      (clk),
    .rst_n    (rst_n),
    .step     (advance),
    .sample   (sample_r),
    .focus    (focus),
    .n_used   (n_used),
    .interval (interval_r),
    .result   (result_nxt)
  );

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {6'd0, result_r.pressed_mask, result_r.active_button,
                       result_r.focus_button};
  assign out_tuser  = result_r.fire;

endmodule

FILE: rtl/bara_hit.sv
// Parallel hit test of the pointer against every configured button, first match wins.
module bara_hit (
  input  logic [bara_pkg::COORD_W-1:0] origin_x,
  input  logic [bara_pkg::COORD_W-1:0] origin_y,
  input  logic [bara_pkg::BTN_W-1:0]   n_used,
  input  bara_pkg::geom_t              geom [bara_pkg::MAX_BUTTONS],
  input  logic [bara_pkg::COORD_W-1:0] pointer_x,
  input  logic [bara_pkg::COORD_W-1:0] pointer_y,
  output logic [bara_pkg::BTN_W-1:0]   focus
);

  logic [bara_pkg::MAX_BUTTONS-1:0] hit;

  always_comb begin
    logic signed [bara_pkg::HIT_W-1:0] left, top, right, bottom, px, py, ox, oy;
    px = bara_pkg::HIT_W'(signed'(pointer_x));
    py = bara_pkg::HIT_W'(signed'(pointer_y));
    ox = bara_pkg::HIT_W'(signed'(origin_x));
    oy = bara_pkg::HIT_W'(signed'(origin_y));
    for (int i = 0; i < bara_pkg::MAX_BUTTONS; i++) begin
      left   = ox + bara_pkg::HIT_W'(signed'(geom[i].off_x));
      top    = oy + bara_pkg::HIT_W'(signed'(geom[i].off_y));
      right  = left + signed'({2'b00, geom[i].size});
      bottom = top + signed'({2'b00, geom[i].size});
      hit[i] = (bara_pkg::BTN_W'(i) < n_used) && (left <= px) && (right > px) &&
               (top <= py) && (bottom > py);
    end
  end

  // Walk from the last button down so the lowest match is left standing.
  always_comb begin
    focus = '0;
    for (int i = bara_pkg::MAX_BUTTONS - 1; i >= 0; i--) begin
      if (hit[i]) begin
        focus = bara_pkg::BTN_W'(i + 1);
      end
    end
  end

endmodule

FILE: rtl/bara_state.sv
// Repeat timer, per-button press countdowns and repeat counters, and result logic.
module bara_state (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            step,
  input  bara_pkg::sample_t               sample,
  input  logic [bara_pkg::BTN_W-1:0]      focus,
  input  logic [bara_pkg::BTN_W-1:0]      n_used,
  input  logic [bara_pkg::INTERVAL_W-1:0] interval,
  output bara_pkg::result_t               result
);

  logic [bara_pkg::TIME_W-1:0] last_time_r, last_time_nxt;
  logic [bara_pkg::CD_W-1:0]   cd_r  [bara_pkg::MAX_BUTTONS];
  logic [bara_pkg::CD_W-1:0]   cd_nxt [bara_pkg::MAX_BUTTONS];
  logic [bara_pkg::CTR_W-1:0]  ctr_r [bara_pkg::MAX_BUTTONS];
  logic [bara_pkg::CTR_W-1:0]  ctr_nxt [bara_pkg::MAX_BUTTONS];
  logic                        tick;
  logic [bara_pkg::TIME_W-1:0] elapsed;

  assign elapsed = sample.now_ms - last_time_r;
  assign tick    = elapsed >= bara_pkg::TIME_W'(interval);
  assign last_time_nxt = tick ? sample.now_ms : last_time_r;

  always_comb begin
    logic [bara_pkg::CTR_W:0] r;
    logic                     used;
    result.focus_button  = focus;
    result.active_button = '0;
    result.fire          = 1'b0;
    result.pressed_mask  = '0;
    r = '0;
    for (int i = 0; i < bara_pkg::MAX_BUTTONS; i++) begin
      used = bara_pkg::BTN_W'(i) < n_used;
      cd_nxt[i]  = cd_r[i];
      ctr_nxt[i] = ctr_r[i];
      // Age the countdown; an expired press drops its repeat history.
      if (used) begin
        if (cd_r[i] != '0) begin
          cd_nxt[i] = cd_r[i] - 1'b1;
        end
        if (cd_nxt[i] == '0) begin
          ctr_nxt[i] = '0;
        end
      end
      if (focus == bara_pkg::BTN_W'(i + 1)) begin
        if (sample.press_edge) begin
          cd_nxt[i]            = bara_pkg::PRESS_SAMPLES;
          ctr_nxt[i]           = '0;
          result.fire          = 1'b1;
          result.active_button = focus;
        end else if (sample.is_down) begin
          cd_nxt[i]            = bara_pkg::PRESS_SAMPLES;
          result.active_button = focus;
          if (tick) begin
            r = {1'b0, ctr_nxt[i]} + 1'b1;
            if (r < (bara_pkg::CTR_W+1)'(bara_pkg::ACCEL_LEN)) begin
              ctr_nxt[i] = r[bara_pkg::CTR_W-1:0];
              if (bara_pkg::accel_gate(r[bara_pkg::CTR_W-1:0])) begin
                result.fire = 1'b1;
              end else begin
                result.active_button = '0;
              end
            end else begin
              ctr_nxt[i]  = bara_pkg::ACCEL_TOP;
              result.fire = 1'b1;
            end
          end
        end
      end
      result.pressed_mask[i] = used && (cd_nxt[i] != '0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_time_r <= '0;
      for (int i = 0; i < bara_pkg::MAX_BUTTONS; i++) begin
        cd_r[i]  <= '0;
        ctr_r[i] <= '0;
      end
    end else if (step) begin
      last_time_r <= last_time_nxt;
      for (int i = 0; i < bara_pkg::MAX_BUTTONS; i++) begin
        cd_r[i]  <= cd_nxt[i];
        ctr_r[i] <= ctr_nxt[i];
      end
    end
  end

endmodule
